// ===== hdl/wwcf_pkg.sv =====
// shared types and constants of the whole-word censor filter
package wwcf_pkg;

  localparam int unsigned CharW           = 16;
  localparam int unsigned LenW            = 4;
  localparam int unsigned MaxChars        = 8;
  localparam int unsigned IdxW            = $clog2(MaxChars);
  localparam int unsigned SlotsHw         = 3;
  localparam int unsigned CfgIdxW         = 3;
  localparam int unsigned CfgDataW        = 64;
  localparam int unsigned CmdDepth        = 2;
  localparam int unsigned MaxWordCharsDef = 8;
  localparam int unsigned BlockedSlotsDef = 3;

  localparam logic [CharW-1:0] SpaceChar = 16'd32;
  localparam logic [CharW-1:0] MaskChar  = 16'd42;

  typedef enum logic [CfgIdxW-1:0] {
    CfgEnable     = 3'd0,
    CfgWord0Head  = 3'd1,
    CfgWord0Tail  = 3'd2,
    CfgWord1Head  = 3'd3,
    CfgWord1Tail  = 3'd4,
    CfgWord2Head  = 3'd5,
    CfgWord2Tail  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [CharW-1:0] in_char;
    logic             in_message_end;
  } in_t;

  typedef struct packed {
    logic [CharW-1:0] out_char;
    logic             run_end;
    logic             out_message_end;
  } out_t;

  // one burst for the back end: buffered token, then an optional trailing char
  typedef struct packed {
    logic [MaxChars-1:0][CharW-1:0] chars;
    logic [LenW-1:0]                len;
    logic                           masked;
    logic                           tail_valid;
    logic [CharW-1:0]               tail_char;
    logic                           msg_end;
  } cmd_t;

endpackage

// ===== hdl/wwcf_front.sv =====
// front end: config registers, token buffer and blocked-word match
module wwcf_front import wwcf_pkg::*; #(
  parameter int unsigned MAX_WORD_CHARS = MaxWordCharsDef,
  parameter int unsigned BLOCKED_SLOTS  = BlockedSlotsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                accept_i,
  input  in_t                 req_i,
  output logic                cmd_valid_o,
  output cmd_t                cmd_o
);

  logic                filter_en_q;
  logic [CfgDataW-1:0] head_q [SlotsHw];
  logic [CfgDataW-1:0] tail_q [SlotsHw];

  logic [CharW-1:0] store_q [MAX_WORD_CHARS];
  logic [CharW-1:0] wr_store [MAX_WORD_CHARS];
  logic [CharW-1:0] m_chars [MAX_WORD_CHARS];
  logic [LenW-1:0]  len_q, len_d, m_len;
  logic             ovf_q, ovf_d;
  logic             is_space, norm, match;
  logic [CharW-1:0] wchar [SlotsHw][MaxChars];
  logic [LenW-1:0]  wlen [SlotsHw];

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_en_q <= 1'b0;
      for (int s = 0; s < SlotsHw; s++) begin
        head_q[s] <= '0;
        tail_q[s] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgEnable:    filter_en_q <= cfg_data_i[0];
        CfgWord0Head: head_q[0] <= cfg_data_i;
        CfgWord0Tail: tail_q[0] <= cfg_data_i;
        CfgWord1Head: head_q[1] <= cfg_data_i;
        CfgWord1Tail: tail_q[1] <= cfg_data_i;
        CfgWord2Head: head_q[2] <= cfg_data_i;
        CfgWord2Tail: tail_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign is_space = (req_i.in_char == SpaceChar);
  assign norm = filter_en_q && !is_space && !ovf_q && (len_q < LenW'(MAX_WORD_CHARS));

  always_comb begin
    for (int k = 0; k < MAX_WORD_CHARS; k++) begin
      wr_store[k] = (len_q == LenW'(k)) ? req_i.in_char : store_q[k];
      m_chars[k]  = norm ? wr_store[k] : store_q[k];
    end
    m_len = norm ? len_q + LenW'(1) : len_q;
  end

  // blocked word characters and lengths
  always_comb begin
    for (int s = 0; s < SlotsHw; s++) begin
      for (int k = 0; k < MaxChars; k++) begin
        if (k < 4) begin
          wchar[s][k] = head_q[s][CharW*k +: CharW];
        end else begin
          wchar[s][k] = tail_q[s][CharW*(k-4) +: CharW];
        end
      end
      wlen[s] = LenW'(MaxChars);
      for (int k = MaxChars - 1; k >= 0; k--) begin
        if (wchar[s][k] == '0) begin
          wlen[s] = LenW'(k);
        end
      end
    end
  end

  // whole-token compare
  always_comb begin
    logic same;
    match = 1'b0;
    for (int s = 0; s < BLOCKED_SLOTS; s++) begin
      same = (wlen[s] == m_len);
      for (int k = 0; k < MAX_WORD_CHARS; k++) begin
        if ((LenW'(k) < m_len) && (wchar[s][k] != m_chars[k])) begin
          same = 1'b0;
        end
      end
      if (same && (m_len != '0)) begin
        match = 1'b1;
      end
    end
  end

  // classify the request
  always_comb begin
    cmd_valid_o = 1'b1;
    cmd_o = '0;
    for (int k = 0; k < MAX_WORD_CHARS; k++) begin
      cmd_o.chars[k] = m_chars[k];
    end
    cmd_o.len        = len_q;
    cmd_o.masked     = 1'b0;
    cmd_o.tail_valid = 1'b1;
    cmd_o.tail_char  = req_i.in_char;
    cmd_o.msg_end    = req_i.in_message_end;
    len_d = '0;
    ovf_d = 1'b0;
    if (!filter_en_q) begin
      len_d = '0;
    end else if (is_space) begin
      cmd_o.masked = match;
    end else if (ovf_q) begin
      cmd_o.len = '0;
      ovf_d     = 1'b1;
    end else if (!norm) begin
      ovf_d = 1'b1;
    end else begin
      len_d            = m_len;
      cmd_o.len        = m_len;
      cmd_o.masked     = match;
      cmd_o.tail_valid = 1'b0;
      cmd_valid_o      = req_i.in_message_end;
    end
    if (req_i.in_message_end) begin
      len_d = '0;
      ovf_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      ovf_q <= 1'b0;
    end else if (accept_i) begin
      len_q <= len_d;
      ovf_q <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && norm) begin
      for (int k = 0; k < MAX_WORD_CHARS; k++) begin
        store_q[k] <= wr_store[k];
      end
    end
  end

endmodule

// ===== hdl/wwcf_cmd_fifo.sv =====
// short command queue between front and back end
module wwcf_cmd_fifo import wwcf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t cmd_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (CmdDepth > 1) ? $clog2(CmdDepth) : 1;
  localparam int unsigned CntW = $clog2(CmdDepth + 1);

  cmd_t            mem_q [CmdDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(CmdDepth));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(CmdDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(CmdDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ===== hdl/wwcf_back.sv =====
// back end: plays commands one char a cycle into the result reg unless stalled
module wwcf_back import wwcf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  input  logic cmd_empty_i,
  output logic cmd_pop_o,
  output out_t res_o,
  output logic empty_o,
  input  logic pop_i
);

  logic [LenW-1:0]  pos_q, total;
  out_t             out_q;
  logic             out_valid_q;
  logic             step, last;
  logic [CharW-1:0] emit_char;

  assign total = cmd_i.len + LenW'(cmd_i.tail_valid);
  assign last  = ((pos_q + LenW'(1)) == total);
  assign step  = !cmd_empty_i && (!out_valid_q || pop_i);

  always_comb begin
    if (pos_q < cmd_i.len) begin
      emit_char = cmd_i.masked ? MaskChar : cmd_i.chars[pos_q[IdxW-1:0]];
    end else begin
      emit_char = cmd_i.tail_char;
    end
  end

  assign cmd_pop_o = step && last;
  assign res_o     = out_q;
  assign empty_o   = !out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
      pos_q       <= last ? '0 : pos_q + LenW'(1);
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q.out_char        <= emit_char;
      out_q.run_end         <= last;
      out_q.out_message_end <= last && cmd_i.msg_end;
    end
  end

`ifndef NO_ASSERTIONS
  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_empty_i |-> (pos_q < total))
    else $error("burst position past end of command");
  a_pos_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && last) |=> (pos_q == '0))
    else $error("burst position not cleared after last result");
  a_msg_end_on_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.out_message_end) |-> out_q.run_end)
    else $error("message end flagged on a result that does not close its request");
`endif

endmodule

// ===== hdl/whole_word_censor_filter_top.sv =====
// top level of the whole-word censor filter
// a request (one 16-bit character plus a message-end flag) is taken in the
// cycle it is pushed whenever the two-entry command queue has room. the front
// end buffers up to MAX_WORD_CHARS characters of a token and, at a space, at
// message end or when the buffer overflows, turns the token and the boundary
// character into one command. the back end plays each command out at one
// result per clock while results are popped; a request closing a token of
// n characters gives n+1 results (n when it ends on message end without a
// space) and a plain pass-through request gives one. the sustained rate is
// set by that single result port: characters in equal results out, so on
// average one request per cycle once the queue absorbs the bursts.
// there is no clearing pass after reset; the token buffer is only read below
// its fill count
module whole_word_censor_filter_top import wwcf_pkg::*; #(
  parameter int unsigned MAX_WORD_CHARS = MaxWordCharsDef,
  parameter int unsigned BLOCKED_SLOTS  = BlockedSlotsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // request side
  input  logic                push,
  input  in_t                 req_i,
  output logic                full,
  // result side
  output out_t                res_o,
  output logic                empty,
  input  logic                pop
);

  logic accept;
  logic cmd_valid, cmd_full, cmd_empty, cmd_pop;
  cmd_t cmd_in, cmd_head;

  // the front end never holds a request, so the queue being full is the only stall
  assign full   = cmd_full;
  assign accept = push && !cmd_full;

  wwcf_front #(
    .MAX_WORD_CHARS (MAX_WORD_CHARS),
    .BLOCKED_SLOTS  (BLOCKED_SLOTS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .req_i       (req_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd_in)
  );

  // a request that only extends the buffered token sends no command
  wwcf_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept && cmd_valid),
    .cmd_i   (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .cmd_o   (cmd_head),
    .empty_o (cmd_empty)
  );

  // result register sits in the back end; stalls reach the front via the queue
  wwcf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_head),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_o       (res_o),
    .empty_o     (empty),
    .pop_i       (pop && !empty)
  );

endmodule
